/* rtl/waypoint_steering_decision_top_assert.svh */
// Assertion macros used by the top-level RTL file of the steering decision block
`ifndef WAYPOINT_STEERING_DECISION_TOP_ASSERT_SVH
`define WAYPOINT_STEERING_DECISION_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define WSD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define WSD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/wsd_pkg.sv */
`default_nettype none
package wsd_pkg;

  // Defaults for the top-level parameters
  localparam int POS_WIDTH_DEF    = 24;
  localparam int CORDIC_STEPS_DEF = 16;

  // Angle accumulator width (Q.30 radians plus quadrant offset)
  localparam int ANG_W   = 34;
  // CORDIC x/y working width and normalisation window [2^40, 2^41)
  localparam int CX_W    = 44;
  localparam int NORM_HI = 41;
  localparam int NORM_LO = 40;
  // Multiplier digit size in bits
  localparam int MUL_DIGIT = 4;

  localparam logic signed [ANG_W-1:0] ANG_PI = 34'sd3373259426;
  localparam logic [13:0] ERR_MAX   = 14'd12868;
  localparam logic [13:0] ONE_Q13   = 14'd8192;
  localparam int          ERR_SHIFT = 17;

  // Configuration port
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_ARRIVE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FINE   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COARSE = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 8'd3;

  localparam logic [15:0] ARRIVE_RST = 16'd6554;
  localparam logic [13:0] FINE_RST   = 14'd819;
  localparam logic [13:0] COARSE_RST = 14'd2458;
  localparam logic [13:0] GAIN_RST   = 14'd1638;

  // Arctangent of 2^-i in Q.30 radians
  function automatic logic [30:0] atan_q30(input logic [4:0] idx);
    logic [30:0] v;
    case (idx)
      5'd0:  v = 31'd843314856;
      5'd1:  v = 31'd497837829;
      5'd2:  v = 31'd263043836;
      5'd3:  v = 31'd133525158;
      5'd4:  v = 31'd67021686;
      5'd5:  v = 31'd33543515;
      5'd6:  v = 31'd16775850;
      5'd7:  v = 31'd8388437;
      5'd8:  v = 31'd4194282;
      5'd9:  v = 31'd2097149;
      5'd10: v = 31'd1048575;
      5'd11: v = 31'd524287;
      5'd12: v = 31'd262143;
      5'd13: v = 31'd131071;
      5'd14: v = 31'd65535;
      5'd15: v = 31'd32767;
      5'd16: v = 31'd16383;
      5'd17: v = 31'd8191;
      5'd18: v = 31'd4095;
      5'd19: v = 31'd2047;
      5'd20: v = 31'd1023;
      5'd21: v = 31'd511;
      5'd22: v = 31'd255;
      5'd23: v = 31'd127;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

/* rtl/waypoint_steering_decision_top.sv */
`default_nettype none
// Channel | Handshake             | Payload
// in      | in_tvalid/in_tready   | in_tdata: pos_x, pos_y, quat_w, waypoint_x, waypoint_y
// out     | out_tvalid/out_tready | out_tdata: steering, throttle_full, waypoint_reached
// cfg     | cfg_valid/cfg_ready   | cfg_index, cfg_data
//
// One item at a time. Each item runs its products through the digit-serial
// multiplier and its square roots through the square-root unit; the CORDIC
// normalises its operands by one-bit shifts (up to 40) before each angle.
// rst_n is synchronous; there is no clearing pass. A stalled result waits in
// the output register while the next item is already accepted and worked on.
// cfg_ready is always high.
`include "waypoint_steering_decision_top_assert.svh"
module waypoint_steering_decision_top #(
  parameter int POS_WIDTH    = wsd_pkg::POS_WIDTH_DEF,
  parameter int CORDIC_STEPS = wsd_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // pos_x, pos_y, quat_w, waypoint_x, waypoint_y, zero fill
  input  wire logic [((4*POS_WIDTH+16+7)/8)*8-1:0] in_tdata,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // steering[14:0], throttle_full[15], waypoint_reached[16], zero fill
  output logic [23:0]                            out_tdata,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [wsd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [wsd_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int P      = POS_WIDTH;
  localparam int DW     = P + 1;
  localparam int DSH    = (P > 31) ? 1 : 0;
  localparam int PW     = 2 * DW;
  localparam int AC_W   = PW + 1;
  localparam int SQ_W   = 2 * DW + 2;
  localparam int RT_W   = SQ_W / 2;
  localparam int DIST_W = RT_W + 1;
  localparam int VW     = 2 * DW + 2;
  localparam int AW     = wsd_pkg::ANG_W;
  localparam int DIFF_W = AW + 3;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DIFF   = 4'd1;
  localparam logic [3:0] S_MUL_X  = 4'd2;
  localparam logic [3:0] S_MUL_Y  = 4'd3;
  localparam logic [3:0] S_SQRT_D = 4'd4;
  localparam logic [3:0] S_MUL_W  = 4'd5;
  localparam logic [3:0] S_SQRT_W = 4'd6;
  localparam logic [3:0] S_COR_H  = 4'd7;
  localparam logic [3:0] S_COR_B  = 4'd8;
  localparam logic [3:0] S_WRAP   = 4'd9;
  localparam logic [3:0] S_MUL_1  = 4'd10;
  localparam logic [3:0] S_MUL_2  = 4'd11;
  localparam logic [3:0] S_MUL_3  = 4'd12;
  localparam logic [3:0] S_MUL_4  = 4'd13;
  localparam logic [3:0] S_COR_E  = 4'd14;
  localparam logic [3:0] S_DECIDE = 4'd15;

  localparam logic [SQ_W-1:0]          W_ONE    = SQ_W'(1) << 30;
  localparam logic signed [DIFF_W-1:0] PI_D     = {{(DIFF_W - AW){1'b0}}, wsd_pkg::ANG_PI};
  localparam logic signed [DIFF_W-1:0] TWO_PI_D = PI_D <<< 1;

  // Control state
  logic [3:0]              state_r;
  logic                    run_r;
  logic                    out_valid_r;
  logic [23:0]             out_data_r;
  logic                    primed_r;
  logic [P-1:0]            prev_x_r, prev_y_r;
  logic [DIST_W-1:0]       prev_dist_r;
  logic signed [15:0]      steer_hold_r;
  logic [15:0]             arrive_r;
  logic [13:0]             fine_r, coarse_r, gain_r;

  // Item payload
  logic [P-1:0]            px_r, py_r, wx_r, wy_r;
  logic [15:0]             w_r;
  logic signed [DW-1:0]    dx_r, dy_r, a_r, b_r;
  logic [AC_W-1:0]         sq_r;
  logic [DIST_W-1:0]       dist_r;
  logic signed [DIFF_W-1:0] heading_r, diff_r;
  logic signed [AC_W-1:0]  cr_r, dt_r;
  logic [13:0]             err_r;

  // Unit hookup
  logic                    is_mul, is_sqrt, is_cor;
  logic                    mul_start, mul_done, mul_neg;
  logic [DW-1:0]           mul_a, mul_b;
  logic [PW-1:0]           mul_p;
  logic signed [AC_W-1:0]  prod_s;
  logic                    sq_start, sq_done;
  logic [SQ_W-1:0]         sq_in;
  logic [RT_W-1:0]         sq_root;
  logic                    cor_start, cor_done;
  logic signed [VW-1:0]    cor_x, cor_y;
  logic signed [AW-1:0]    cor_z;

  // Decision signals
  logic [DW-1:0]           hx, hy, ha, hb;
  logic [15:0]             wmag;
  logic [AC_W-1:0]         dt_mag, cr_mag;
  logic signed [P:0]       ox_e, oy_e;
  logic signed [DIFF_W-1:0] z_ext;
  logic [AW-1:0]           zm;
  logic [AW:0]             zr;
  logic [13:0]             err_nxt;
  logic [DIST_W-1:0]       pdist;
  logic                    nan_path, grow, shrink, orient, skip_err;
  logic signed [15:0]      steer_nxt;
  logic                    thr_nxt, reached_nxt;
  logic                    out_free, out_load;

  function automatic logic [DW-1:0] half_mag(input logic signed [DW-1:0] v);
    logic [DW-1:0] m;
    m = v[DW-1] ? DW'(unsigned'(-v)) : DW'(unsigned'(v));
    return m >> DSH;
  endfunction

  function automatic logic signed [15:0] signed_mag(input logic pos, input logic [13:0] m);
    logic signed [15:0] s;
    s = $signed({2'b00, m});
    return pos ? s : -s;
  endfunction

  // Magnitudes and operand selection
  always_comb begin
    hx     = half_mag(dx_r);
    hy     = half_mag(dy_r);
    ha     = half_mag(a_r);
    hb     = half_mag(b_r);
    wmag   = w_r[15] ? 16'(-$signed(w_r)) : w_r;
    dt_mag = dt_r[AC_W-1] ? AC_W'(unsigned'(-dt_r)) : AC_W'(unsigned'(dt_r));
    cr_mag = cr_r[AC_W-1] ? AC_W'(unsigned'(-cr_r)) : AC_W'(unsigned'(cr_r));
    ox_e   = primed_r ? $signed({prev_x_r[P-1], prev_x_r}) : $signed({px_r[P-1], px_r});
    oy_e   = primed_r ? $signed({prev_y_r[P-1], prev_y_r}) : $signed({py_r[P-1], py_r});
    is_mul  = state_r inside {S_MUL_X, S_MUL_Y, S_MUL_W, S_MUL_1, S_MUL_2, S_MUL_3, S_MUL_4};
    is_sqrt = state_r inside {S_SQRT_D, S_SQRT_W};
    is_cor  = state_r inside {S_COR_H, S_COR_B, S_COR_E};
    mul_a   = hx;
    mul_b   = hx;
    mul_neg = 1'b0;
    case (state_r)
      S_MUL_Y: begin mul_a = hy; mul_b = hy; end
      S_MUL_W: begin
        mul_a = {{(DW - 16){1'b0}}, wmag};
        mul_b = {{(DW - 16){1'b0}}, wmag};
      end
      S_MUL_1: begin mul_b = ha; mul_neg = dx_r[DW-1] ^ a_r[DW-1]; end
      S_MUL_2: begin mul_a = hy; mul_b = hb; mul_neg = dy_r[DW-1] ^ b_r[DW-1]; end
      S_MUL_3: begin mul_b = hb; mul_neg = dx_r[DW-1] ^ b_r[DW-1]; end
      S_MUL_4: begin mul_a = hy; mul_b = ha; mul_neg = dy_r[DW-1] ^ a_r[DW-1]; end
      default: ;
    endcase
    prod_s = mul_neg ? -$signed({1'b0, mul_p}) : $signed({1'b0, mul_p});
    sq_in  = (state_r == S_SQRT_W) ? (W_ONE - SQ_W'(mul_p)) : SQ_W'(sq_r);
    case (state_r)
      S_COR_H: begin
        cor_x = $signed({{(VW - 16){w_r[15]}}, w_r});
        cor_y = $signed({{(VW - RT_W){1'b0}}, sq_root});
      end
      S_COR_B: begin
        cor_x = $signed({{(VW - DW){dx_r[DW-1]}}, dx_r});
        cor_y = $signed({{(VW - DW){dy_r[DW-1]}}, dy_r});
      end
      default: begin
        cor_x = $signed({{(VW - AC_W){1'b0}}, dt_mag});
        cor_y = $signed({{(VW - AC_W){1'b0}}, cr_mag});
      end
    endcase
    mul_start = is_mul && !run_r;
    sq_start  = is_sqrt && !run_r;
    cor_start = is_cor && !run_r;
  end

  // Heading error rounding and steering choice
  always_comb begin
    z_ext    = $signed({{(DIFF_W - AW){cor_z[AW-1]}}, cor_z});
    zm       = cor_z[AW-1] ? AW'(unsigned'(-cor_z)) : AW'(unsigned'(cor_z));
    zr       = {1'b0, zm} + (AW + 1)'(65536);
    err_nxt  = (zr[AW:wsd_pkg::ERR_SHIFT] > (AW + 1 - wsd_pkg::ERR_SHIFT)'(wsd_pkg::ERR_MAX))
               ? wsd_pkg::ERR_MAX : zr[wsd_pkg::ERR_SHIFT+13:wsd_pkg::ERR_SHIFT];
    pdist    = primed_r ? prev_dist_r : dist_r;
    nan_path = (dist_r == '0);
    grow     = dist_r > pdist;
    shrink   = dist_r < pdist;
    orient   = !diff_r[DIFF_W-1] && (diff_r != '0);
    skip_err = nan_path || ((a_r == '0) && (b_r == '0));
    steer_nxt = steer_hold_r;
    thr_nxt   = 1'b0;
    if (nan_path) begin
      if (grow) steer_nxt = signed_mag(orient, wsd_pkg::ONE_Q13);
    end else if ((err_r <= fine_r) && shrink) begin
      steer_nxt = '0;
      thr_nxt   = 1'b1;
    end else if ((err_r <= coarse_r) && (err_r > fine_r)) begin
      steer_nxt = signed_mag(orient, gain_r);
    end else if (err_r > coarse_r) begin
      steer_nxt = signed_mag(orient, err_r);
    end else if (grow) begin
      steer_nxt = signed_mag(orient, wsd_pkg::ONE_Q13);
    end
    reached_nxt = dist_r < {{(DIST_W - 16){1'b0}}, arrive_r};
    out_free    = !out_valid_r || out_tready;
    out_load    = (state_r == S_DECIDE) && out_free;
  end

  // Sequencer, result register, carried state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      run_r        <= 1'b0;
      out_valid_r  <= 1'b0;
      primed_r     <= 1'b0;
      prev_x_r     <= '0;
      prev_y_r     <= '0;
      prev_dist_r  <= '0;
      steer_hold_r <= '0;
      arrive_r     <= wsd_pkg::ARRIVE_RST;
      fine_r       <= wsd_pkg::FINE_RST;
      coarse_r     <= wsd_pkg::COARSE_RST;
      gain_r       <= wsd_pkg::GAIN_RST;
    end else begin
      if (mul_start || sq_start || cor_start) run_r <= 1'b1;
      // Load a new result when the register frees, else drop it once taken
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE:   if (in_tvalid) state_r <= S_DIFF;
        S_DIFF:   state_r <= S_MUL_X;
        S_MUL_X:  if (mul_done) begin state_r <= S_MUL_Y;  run_r <= 1'b0; end
        S_MUL_Y:  if (mul_done) begin state_r <= S_SQRT_D; run_r <= 1'b0; end
        S_SQRT_D: if (sq_done)  begin state_r <= S_MUL_W;  run_r <= 1'b0; end
        S_MUL_W:  if (mul_done) begin state_r <= S_SQRT_W; run_r <= 1'b0; end
        S_SQRT_W: if (sq_done)  begin state_r <= S_COR_H;  run_r <= 1'b0; end
        S_COR_H:  if (cor_done) begin state_r <= S_COR_B;  run_r <= 1'b0; end
        S_COR_B:  if (cor_done) begin state_r <= S_WRAP;   run_r <= 1'b0; end
        S_WRAP: begin
          if ((diff_r <= PI_D) && (diff_r >= -PI_D)) begin
            state_r <= skip_err ? S_DECIDE : S_MUL_1;
          end
        end
        S_MUL_1:  if (mul_done) begin state_r <= S_MUL_2;  run_r <= 1'b0; end
        S_MUL_2:  if (mul_done) begin state_r <= S_MUL_3;  run_r <= 1'b0; end
        S_MUL_3:  if (mul_done) begin state_r <= S_MUL_4;  run_r <= 1'b0; end
        S_MUL_4:  if (mul_done) begin state_r <= S_COR_E;  run_r <= 1'b0; end
        S_COR_E:  if (cor_done) begin state_r <= S_DECIDE; run_r <= 1'b0; end
        S_DECIDE: begin
          if (out_free) begin
            steer_hold_r <= steer_nxt;
            prev_x_r     <= px_r;
            prev_y_r     <= py_r;
            prev_dist_r  <= dist_r;
            primed_r     <= 1'b1;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
      // Configuration transaction
      if (cfg_valid) begin
        case (cfg_index)
          wsd_pkg::REG_ARRIVE: arrive_r <= cfg_data;
          wsd_pkg::REG_FINE:   fine_r   <= cfg_data[13:0];
          wsd_pkg::REG_COARSE: coarse_r <= cfg_data[13:0];
          wsd_pkg::REG_GAIN:   gain_r   <= cfg_data[13:0];
          default: ;
        endcase
      end
    end
  end

  // Item datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          px_r <= in_tdata[P-1:0];
          py_r <= in_tdata[2*P-1:P];
          w_r  <= in_tdata[2*P+15:2*P];
          wx_r <= in_tdata[3*P+15:2*P+16];
          wy_r <= in_tdata[4*P+15:3*P+16];
        end
      end
      S_DIFF: begin
        dx_r <= $signed({wx_r[P-1], wx_r}) - $signed({px_r[P-1], px_r});
        dy_r <= $signed({wy_r[P-1], wy_r}) - $signed({py_r[P-1], py_r});
        a_r  <= $signed({py_r[P-1], py_r}) - oy_e;
        b_r  <= $signed({px_r[P-1], px_r}) - ox_e;
      end
      S_MUL_X:  if (mul_done) sq_r <= AC_W'(mul_p);
      S_MUL_Y:  if (mul_done) sq_r <= sq_r + AC_W'(mul_p);
      S_SQRT_D: if (sq_done) dist_r <= DIST_W'(sq_root) << DSH;
      S_COR_H:  if (cor_done) heading_r <= z_ext <<< 1;
      S_COR_B:  if (cor_done) diff_r <= z_ext - heading_r;
      S_WRAP: begin
        if (diff_r > PI_D) begin
          diff_r <= diff_r - TWO_PI_D;
        end else if (diff_r < -PI_D) begin
          diff_r <= diff_r + TWO_PI_D;
        end else if (skip_err) begin
          err_r <= '0;
        end
      end
      S_MUL_1:  if (mul_done) cr_r <= prod_s;
      S_MUL_2:  if (mul_done) cr_r <= cr_r - prod_s;
      S_MUL_3:  if (mul_done) dt_r <= prod_s;
      S_MUL_4:  if (mul_done) dt_r <= dt_r + prod_s;
      S_COR_E:  if (cor_done) err_r <= err_nxt;
      S_DECIDE: begin
        if (out_free) begin
          out_data_r <= {7'd0, reached_nxt, thr_nxt, steer_nxt[14:0]};
        end
      end
      default: ;
    endcase
  end

  wsd_mul #(.W(DW)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  wsd_sqrt #(.W(SQ_W)) u_sqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (sq_start),
    .rad_in (sq_in),
    .done   (sq_done),
    .root   (sq_root)
  );

  wsd_cordic #(.VW(VW), .STEPS(CORDIC_STEPS)) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cor_start),
    .x_in  (cor_x),
    .y_in  (cor_y),
    .done  (cor_done),
    .z_out (cor_z)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign cfg_ready  = 1'b1;

  `WSD_ASSERT_IMP(a_mul_done_in_step, mul_done, is_mul, "multiplier finished outside a multiply step")
  `WSD_ASSERT_IMP(a_cor_done_in_step, cor_done, is_cor, "CORDIC finished outside an angle step")
  `WSD_ASSERT_NXT(a_load_returns_idle, out_load, (state_r == S_IDLE) && out_valid_r, "result load did not complete")
  `WSD_ASSERT_IMP(a_steer_range, out_tvalid, ($signed(out_tdata[14:0]) <= 15'sd12868) && ($signed(out_tdata[14:0]) >= -15'sd12868), "steering out of range")

endmodule
`default_nettype wire

/* rtl/wsd_mul.sv */
`default_nettype none
// Unsigned digit-serial multiplier: one MUL_DIGIT-bit digit of b per cycle
module wsd_mul #(
  parameter int W = 25
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  input  wire logic [W-1:0]   a,
  input  wire logic [W-1:0]   b,
  output logic                done,
  output logic [2*W-1:0]      p
);

  localparam int MD    = wsd_pkg::MUL_DIGIT;
  localparam int STEPS = (W + MD - 1) / MD;
  localparam int CW    = $clog2(STEPS + 1);

  logic            busy_r;
  logic            done_r;
  logic [CW-1:0]   cnt_r;
  logic [2*W-1:0]  acc_r;
  logic [2*W-1:0]  a_sh_r;
  logic [W-1:0]    b_sh_r;
  logic [2*W-1:0]  pp;

  // Partial product of the current digit
  always_comb begin
    pp = '0;
    for (int j = 0; j < MD; j++) begin
      if (b_sh_r[j]) begin
        pp = pp + (a_sh_r << j);
      end
    end
  end

  // Control: count digits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == CW'(STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: accumulate and shift
  always_ff @(posedge clk) begin
    if (start) begin
      acc_r  <= '0;
      a_sh_r <= {{W{1'b0}}, a};
      b_sh_r <= b;
    end else if (busy_r) begin
      acc_r  <= acc_r + pp;
      a_sh_r <= a_sh_r << MD;
      b_sh_r <= b_sh_r >> MD;
    end
  end

  assign done = done_r;
  assign p    = acc_r;

endmodule
`default_nettype wire

/* rtl/wsd_sqrt.sv */
`default_nettype none
// Integer square root, floor, two radicand bits per cycle
module wsd_sqrt #(
  parameter int W = 52
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  input  wire logic [W-1:0]   rad_in,
  output logic                done,
  output logic [W/2-1:0]      root
);

  localparam int HW = W / 2;
  localparam int RW = HW + 2;
  localparam int CW = $clog2(HW + 1);

  logic           busy_r;
  logic           done_r;
  logic [CW-1:0]  cnt_r;
  logic [W-1:0]   rad_r;
  logic [RW-1:0]  rem_r;
  logic [HW-1:0]  root_r;
  logic [RW-1:0]  r2;
  logic [RW-1:0]  trial;
  logic           ge;

  // One digit of the root
  always_comb begin
    r2    = {rem_r[RW-3:0], rad_r[W-1:W-2]};
    trial = {root_r, 2'b01};
    ge    = (r2 >= trial);
  end

  // Control: count digits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == CW'(HW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: shift radicand, update remainder and root
  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= rad_in;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= rad_r << 2;
      rem_r  <= ge ? (r2 - trial) : r2;
      root_r <= {root_r[HW-2:0], ge};
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule
`default_nettype wire

/* rtl/wsd_cordic.sv */
`default_nettype none
// Vectoring CORDIC: atan2(y, x) in Q.30 radians, one shift or rotation per cycle
module wsd_cordic #(
  parameter int VW    = 52,
  parameter int STEPS = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  input  wire logic signed [VW-1:0]              x_in,
  input  wire logic signed [VW-1:0]              y_in,
  output logic                                   done,
  output logic signed [wsd_pkg::ANG_W-1:0]       z_out
);

  localparam int NW = (VW > wsd_pkg::NORM_HI + 1) ? VW : wsd_pkg::NORM_HI + 1;
  localparam int AW = wsd_pkg::ANG_W;
  localparam int XW = wsd_pkg::CX_W;

  localparam logic [1:0] C_IDLE = 2'd0;
  localparam logic [1:0] C_NORM = 2'd1;
  localparam logic [1:0] C_ITER = 2'd2;

  logic [1:0]            st_r;
  logic                  done_r;
  logic [NW-1:0]         ux_r, uy_r;
  logic                  yneg_r;
  logic signed [XW-1:0]  cx_r, cy_r;
  logic signed [AW-1:0]  z_r;
  logic [4:0]            i_r;

  logic                  neg, is_zero;
  logic signed [VW-1:0]  xv, yv;
  logic signed [AW-1:0]  base;
  logic [NW-1:0]         mx;
  logic                  big, tiny;
  logic signed [XW-1:0]  ld_x, sh_x, sh_y;
  logic signed [AW-1:0]  at;

  // Fold the left half-plane and pick the quadrant offset
  always_comb begin
    neg     = x_in[VW-1];
    is_zero = (x_in == '0) && (y_in == '0);
    xv      = neg ? -x_in : x_in;
    yv      = neg ? -y_in : y_in;
    if (!neg) begin
      base = '0;
    end else if (!y_in[VW-1]) begin
      base = wsd_pkg::ANG_PI;
    end else begin
      base = -wsd_pkg::ANG_PI;
    end
  end

  // Normalisation window test and rotation terms
  always_comb begin
    mx   = (ux_r > uy_r) ? ux_r : uy_r;
    big  = |mx[NW-1:wsd_pkg::NORM_HI];
    tiny = ~|mx[NW-1:wsd_pkg::NORM_LO];
    ld_x = $signed({{(XW - wsd_pkg::NORM_HI){1'b0}}, ux_r[wsd_pkg::NORM_HI-1:0]});
    sh_x = cx_r >>> i_r;
    sh_y = cy_r >>> i_r;
    at   = $signed({{(AW - 31){1'b0}}, wsd_pkg::atan_q30(i_r)});
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= C_IDLE;
      done_r <= 1'b0;
      i_r    <= '0;
    end else begin
      done_r <= 1'b0;
      case (st_r)
        C_IDLE: begin
          if (start) begin
            if (is_zero) begin
              done_r <= 1'b1;
            end else begin
              st_r <= C_NORM;
            end
          end
        end
        C_NORM: begin
          if (!big && !tiny) begin
            i_r  <= '0;
            st_r <= C_ITER;
          end
        end
        C_ITER: begin
          i_r <= i_r + 5'd1;
          if (i_r == 5'(STEPS - 1)) begin
            done_r <= 1'b1;
            st_r   <= C_IDLE;
          end
        end
        default: st_r <= C_IDLE;
      endcase
    end
  end

  // Datapath: load, normalise, rotate
  always_ff @(posedge clk) begin
    case (st_r)
      C_IDLE: begin
        if (start) begin
          ux_r   <= NW'(unsigned'(xv));
          uy_r   <= yv[VW-1] ? NW'(unsigned'(-yv)) : NW'(unsigned'(yv));
          yneg_r <= yv[VW-1];
          z_r    <= is_zero ? '0 : base;
        end
      end
      C_NORM: begin
        if (big) begin
          ux_r <= ux_r >> 1;
          uy_r <= uy_r >> 1;
        end else if (tiny) begin
          ux_r <= ux_r << 1;
          uy_r <= uy_r << 1;
        end else begin
          cx_r <= ld_x;
          cy_r <= yneg_r
                  ? -$signed({{(XW - wsd_pkg::NORM_HI){1'b0}}, uy_r[wsd_pkg::NORM_HI-1:0]})
                  :  $signed({{(XW - wsd_pkg::NORM_HI){1'b0}}, uy_r[wsd_pkg::NORM_HI-1:0]});
        end
      end
      C_ITER: begin
        if (!cy_r[XW-1] && (cy_r != '0)) begin
          cx_r <= cx_r + sh_y;
          cy_r <= cy_r - sh_x;
          z_r  <= z_r + at;
        end else begin
          cx_r <= cx_r - sh_y;
          cy_r <= cy_r + sh_x;
          z_r  <= z_r - at;
        end
      end
      default: ;
    endcase
  end

  assign done  = done_r;
  assign z_out = z_r;

endmodule
`default_nettype wire
